// ===== design/bdm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bayer demosaic package
// Shared constants, types and the per-pixel bilinear interpolation function.
// ----------------------------------------------------------------------------
package bdm_pkg;

  localparam int MAX_WIDTH    = 4096;
  localparam int SAMPLE_W     = 16;
  localparam int PIX_W        = 8;
  localparam int PIX_LSB      = 4;
  localparam int WIDTH_REG_W  = 13;
  localparam int HEIGHT_REG_W = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int SUM_W        = 10;
  localparam int RESULTS      = 4;
  localparam int RECIP3       = 683;
  localparam int RECIP3_SHIFT = 11;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 13'd4096;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd3072;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  // Index is row * 3 + column of a 3x3 neighborhood.
  typedef logic [8:0][PIX_W-1:0] nbhd_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic up;
    logic dn;
    logic lf;
    logic rt;
  } nbr_ok_t;

  typedef struct packed {
    logic r_odd;
    logic c_odd;
    logic r_ge1;
    logic r_ge2;
    logic c_ge1;
    logic c_ge2;
    logic r_last;
    logic c_last;
  } pos_t;

  function automatic logic [PIX_W-1:0] avg_div(logic [SUM_W-1:0] sum, logic [2:0] cnt);
    logic [2*SUM_W-1:0] prod;
    logic [PIX_W-1:0]   res;
    prod = (2*SUM_W)'(sum) * (2*SUM_W)'(RECIP3);
    unique case (cnt)
      3'd1:    res = sum[PIX_W-1:0];
      3'd2:    res = sum[PIX_W:1];
      3'd3:    res = prod[RECIP3_SHIFT +: PIX_W];
      3'd4:    res = sum[PIX_W+1:2];
      default: res = '0;
    endcase
    return res;
  endfunction

  function automatic rgb_t demosaic_px(nbhd_t nb, logic [1:0] phase, nbr_ok_t ok);
    logic [SUM_W-1:0] h_sum;
    logic [SUM_W-1:0] v_sum;
    logic [SUM_W-1:0] x_sum;
    logic [SUM_W-1:0] d_sum;
    logic [2:0]       h_n;
    logic [2:0]       v_n;
    logic [2:0]       x_n;
    logic [2:0]       d_n;
    logic [PIX_W-1:0] h_avg;
    logic [PIX_W-1:0] v_avg;
    logic [PIX_W-1:0] x_avg;
    logic [PIX_W-1:0] d_avg;
    rgb_t             px;
    h_sum = (ok.lf ? SUM_W'(nb[3]) : '0) + (ok.rt ? SUM_W'(nb[5]) : '0);
    v_sum = (ok.up ? SUM_W'(nb[1]) : '0) + (ok.dn ? SUM_W'(nb[7]) : '0);
    h_n   = 3'(ok.lf) + 3'(ok.rt);
    v_n   = 3'(ok.up) + 3'(ok.dn);
    x_sum = h_sum + v_sum;
    x_n   = h_n + v_n;
    d_sum = ((ok.up && ok.lf) ? SUM_W'(nb[0]) : '0) + ((ok.up && ok.rt) ? SUM_W'(nb[2]) : '0)
          + ((ok.dn && ok.lf) ? SUM_W'(nb[6]) : '0) + ((ok.dn && ok.rt) ? SUM_W'(nb[8]) : '0);
    d_n   = 3'(ok.up && ok.lf) + 3'(ok.up && ok.rt) + 3'(ok.dn && ok.lf) + 3'(ok.dn && ok.rt);
    h_avg = avg_div(h_sum, h_n);
    v_avg = avg_div(v_sum, v_n);
    x_avg = avg_div(x_sum, x_n);
    d_avg = avg_div(d_sum, d_n);
    unique case (phase)
      2'd0: begin
        px.red   = nb[4];
        px.green = x_avg;
        px.blue  = d_avg;
      end
      2'd1: begin
        px.red   = h_avg;
        px.green = nb[4];
        px.blue  = v_avg;
      end
      2'd2: begin
        px.red   = v_avg;
        px.green = nb[4];
        px.blue  = h_avg;
      end
      default: begin
        px.red   = d_avg;
        px.green = x_avg;
        px.blue  = nb[4];
      end
    endcase
    return px;
  endfunction

endpackage
`default_nettype wire

// ===== design/bdm_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enable-held read.
// ----------------------------------------------------------------------------
module bdm_ram #(
  parameter int WIDTH = 2 * bdm_pkg::PIX_W,
  parameter int DEPTH = bdm_pkg::MAX_WIDTH,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== design/bayer_rg_bilinear_demosaic.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RGGB Bayer bilinear demosaic
// Converts a raster stream of raw sensor words into RGB pixels using a line
// memory, a 3x3 window and border-aware neighbor averaging.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake               Payload
//  in       sink       in_valid_i/in_stall_o   raw_sample_i
//  out      source     out_valid_o/out_stall_i red_o green_o blue_o
//                                              last_of_run_o frame_end_o
//  cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i cfg_data_i
//
//  A sample enters every cycle unless input stalls; results are registered.
//  A sample at the last column or on the last row gives up to four results,
//  which leave one per cycle unless output stalls; input stalls as they drain.
//  The line memory is read when a sample enters and written one stage later.
//  Reset clears control state and the window; the line memory is not cleared.
//  A downstream stall holds the result group and then the input stage.
// ----------------------------------------------------------------------------
module bayer_rg_bilinear_demosaic #(
  parameter int MAX_WIDTH = bdm_pkg::MAX_WIDTH
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [bdm_pkg::SAMPLE_W-1:0]    raw_sample_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [bdm_pkg::PIX_W-1:0]       red_o,
  output logic      [bdm_pkg::PIX_W-1:0]       green_o,
  output logic      [bdm_pkg::PIX_W-1:0]       blue_o,
  output logic                                 last_of_run_o,
  output logic                                 frame_end_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire bdm_pkg::reg_idx_e               cfg_index_i,
  input  wire logic [bdm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WEFF_W = COL_W + 1;
  localparam int PW     = bdm_pkg::PIX_W;
  localparam int HW     = bdm_pkg::HEIGHT_REG_W;
  localparam int NRES   = bdm_pkg::RESULTS;

  logic [bdm_pkg::WIDTH_REG_W-1:0] width_q;
  logic [HW-1:0]                   height_q;
  logic [COL_W-1:0]                col_q;
  logic [HW-1:0]                   row_q;

  logic [WEFF_W-1:0] w_eff;
  logic [HW-1:0]     h_eff;
  logic [COL_W-1:0]  c_eff;
  logic [HW-1:0]     r_eff;
  logic              c_last;
  logic              r_last;
  logic              in_acc;

  logic                b_valid_q;
  logic [PW-1:0]       b_sample_q;
  logic [COL_W-1:0]    b_col_q;
  bdm_pkg::pos_t       b_pos_q;
  bdm_pkg::pos_t       pos_d;
  logic                fwd_q;
  logic [2*PW-1:0]     fwd_data_q;
  logic [2*PW-1:0]     ram_rdata;
  logic [2*PW-1:0]     line_data;
  logic [2*PW-1:0]     wr_data;
  logic                b_adv;

  bdm_pkg::nbhd_t      win_q;
  bdm_pkg::nbhd_t      win_d;
  bdm_pkg::nbhd_t      nb_p1;
  bdm_pkg::nbhd_t      nb_p2;
  bdm_pkg::nbhd_t      nb_p3;
  bdm_pkg::rgb_t [NRES-1:0] slot_q;
  bdm_pkg::rgb_t [NRES-1:0] slot_d;
  logic [NRES-1:0]     mask_q;
  logic [NRES-1:0]     mask_d;
  logic [NRES-1:0]     mask_rest;
  logic                grp_free;
  logic                out_take;
  logic [1:0]          sel;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bdm_pkg::WIDTH_RESET;
      height_q <= bdm_pkg::HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bdm_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_data_i[bdm_pkg::WIDTH_REG_W-1:0];
        bdm_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data_i[HW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      w_eff = WEFF_W'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      w_eff = WEFF_W'(width_q);
    end
    h_eff  = (height_q == '0) ? HW'(1) : height_q;
    c_eff  = (WEFF_W'(col_q) >= w_eff) ? '0 : col_q;
    r_eff  = (row_q >= h_eff) ? '0 : row_q;
    c_last = (WEFF_W'(c_eff) == w_eff - WEFF_W'(1));
    r_last = (r_eff == h_eff - HW'(1));
    pos_d.r_odd  = r_eff[0];
    pos_d.c_odd  = c_eff[0];
    pos_d.r_ge1  = (r_eff != '0);
    pos_d.r_ge2  = (r_eff > HW'(1));
    pos_d.c_ge1  = (c_eff != '0);
    pos_d.c_ge2  = (c_eff > COL_W'(1));
    pos_d.r_last = r_last;
    pos_d.c_last = c_last;
  end

  assign out_take  = out_valid_o & ~out_stall_i;
  assign mask_rest = mask_q & (mask_q - NRES'(1));
  assign grp_free  = (mask_q == '0) | (out_take & (mask_rest == '0));
  assign b_adv     = b_valid_q & grp_free;
  assign in_stall_o = b_valid_q & ~grp_free;
  assign in_acc    = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      b_valid_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else begin
      if (in_acc) begin
        col_q <= c_last ? '0 : c_eff + COL_W'(1);
        if (c_last) begin
          row_q <= r_last ? '0 : r_eff + HW'(1);
        end else begin
          row_q <= r_eff;
        end
        fwd_q <= b_adv && (c_eff == b_col_q);
      end
      if (in_acc) begin
        b_valid_q <= 1'b1;
      end else if (b_adv) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      b_sample_q <= raw_sample_i[bdm_pkg::PIX_LSB +: PW];
      b_col_q    <= c_eff;
      b_pos_q    <= pos_d;
      fwd_data_q <= wr_data;
    end
  end

  // Each entry packs the older row above the newer row of one column.
  assign line_data = fwd_q ? fwd_data_q : ram_rdata;
  assign wr_data   = {line_data[PW-1:0], b_sample_q};

  bdm_ram #(
    .WIDTH (2 * PW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (b_adv),
    .waddr_i (b_col_q),
    .wdata_i (wr_data),
    .re_i    (in_acc),
    .raddr_i (c_eff),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_d[i*3 + 0] = win_q[i*3 + 1];
      win_d[i*3 + 1] = win_q[i*3 + 2];
    end
    win_d[2] = line_data[2*PW-1:PW];
    win_d[5] = line_data[PW-1:0];
    win_d[8] = b_sample_q;
    nb_p1 = '0;
    nb_p2 = '0;
    nb_p3 = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 2; j++) begin
        nb_p1[i*3 + j] = win_d[i*3 + j + 1];
      end
    end
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 3; j++) begin
        nb_p2[i*3 + j] = win_d[(i + 1)*3 + j];
      end
      for (int j = 0; j < 2; j++) begin
        nb_p3[i*3 + j] = win_d[(i + 1)*3 + j + 1];
      end
    end
  end

  always_comb begin
    slot_d[0] = bdm_pkg::demosaic_px(win_d, {~b_pos_q.r_odd, ~b_pos_q.c_odd},
                                     '{up: b_pos_q.r_ge2, dn: 1'b1,
                                       lf: b_pos_q.c_ge2, rt: 1'b1});
    slot_d[1] = bdm_pkg::demosaic_px(nb_p1, {~b_pos_q.r_odd, b_pos_q.c_odd},
                                     '{up: b_pos_q.r_ge2, dn: 1'b1,
                                       lf: b_pos_q.c_ge1, rt: 1'b0});
    slot_d[2] = bdm_pkg::demosaic_px(nb_p2, {b_pos_q.r_odd, ~b_pos_q.c_odd},
                                     '{up: b_pos_q.r_ge1, dn: 1'b0,
                                       lf: b_pos_q.c_ge2, rt: 1'b1});
    slot_d[3] = bdm_pkg::demosaic_px(nb_p3, {b_pos_q.r_odd, b_pos_q.c_odd},
                                     '{up: b_pos_q.r_ge1, dn: 1'b0,
                                       lf: b_pos_q.c_ge1, rt: 1'b0});
    mask_d[0] = b_pos_q.r_ge1 & b_pos_q.c_ge1;
    mask_d[1] = b_pos_q.r_ge1 & b_pos_q.c_last;
    mask_d[2] = b_pos_q.r_last & b_pos_q.c_ge1;
    mask_d[3] = b_pos_q.r_last & b_pos_q.c_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      mask_q <= '0;
    end else begin
      if (b_adv) begin
        win_q  <= win_d;
        mask_q <= mask_d;
      end else if (out_take) begin
        mask_q <= mask_rest;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      slot_q <= slot_d;
    end
  end

  always_comb begin
    priority if (mask_q[0]) begin
      sel = 2'd0;
    end else if (mask_q[1]) begin
      sel = 2'd1;
    end else if (mask_q[2]) begin
      sel = 2'd2;
    end else if (mask_q[3]) begin
      sel = 2'd3;
    end else begin
      sel = 2'd0;
    end
  end

  assign out_valid_o   = (mask_q != '0);
  assign red_o         = slot_q[sel].red;
  assign green_o       = slot_q[sel].green;
  assign blue_o        = slot_q[sel].blue;
  assign last_of_run_o = (mask_rest == '0);
  assign frame_end_o   = (sel == 2'd3);

`ifndef SYNTHESIS
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (b_valid_q && (mask_q != '0)))
    else $error("input stalled without a waiting item and result group");

  a_frame_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_end_o) |-> last_of_run_o)
    else $error("frame end pixel is not the last result of its sample");

  a_results_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_adv && (mask_d != '0)) |=> out_valid_o)
    else $error("results of an advanced sample did not appear");
`endif

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Testbench for the RGGB Bayer bilinear demosaic
// Streams directed and random raw frames of many sizes through the block while
// both channel sides idle and stall at random. A scoreboard class predicts
// every RGB pixel, and each output transfer is checked field by field.
// ----------------------------------------------------------------------------
module tb;
  import bdm_pkg::*;

  typedef struct packed {
    rgb_t color;
    logic last_of_run;
    logic frame_end;
  } pixel_t;

  typedef enum {NB_CROSS, NB_DIAG, NB_HORIZ, NB_VERT} nbr_kind_e;

  class demosaic_scoreboard;
    int               width_reg;
    int               height_reg;
    int               col_count;
    int               row_count;
    logic [PIX_W-1:0] older_line [MAX_WIDTH];
    logic [PIX_W-1:0] newer_line [MAX_WIDTH];
    logic [PIX_W-1:0] win [9];
    pixel_t           expected_pixels[$];
    int               errors;

    function new();
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      col_count  = 0;
      row_count  = 0;
      errors     = 0;
      foreach (win[i]) win[i] = '0;
      foreach (older_line[i]) begin
        older_line[i] = '0;
        newer_line[i] = '0;
      end
    endfunction

    function void set_register(reg_idx_e idx, logic [CFG_DATA_W-1:0] value);
      if (idx == REG_FRAME_WIDTH) begin
        width_reg = value[WIDTH_REG_W-1:0];
      end else begin
        height_reg = value[HEIGHT_REG_W-1:0];
      end
    endfunction

    function int eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    function int eff_height();
      return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function int frame_pos();
      int c;
      int r;
      c = (col_count >= eff_width()) ? 0 : col_count;
      r = (row_count >= eff_height()) ? 0 : row_count;
      return r * eff_width() + c;
    endfunction

    function bit at_frame_start();
      return frame_pos() == 0;
    endfunction

    function int samples_left();
      return eff_width() * eff_height() - frame_pos();
    endfunction

    function logic [PIX_W-1:0] neighbor_mean(nbr_kind_e kind, int pr, int pc, int wr, int wc,
                                             int w, int h);
      int sum;
      int n;
      int dr;
      int dc;
      int rr;
      int cc;
      bit take;
      sum = 0;
      n   = 0;
      for (dr = -1; dr <= 1; dr++) begin
        for (dc = -1; dc <= 1; dc++) begin
          case (kind)
            NB_CROSS: take = (dr == 0) != (dc == 0);
            NB_DIAG:  take = (dr != 0) && (dc != 0);
            NB_HORIZ: take = (dr == 0) && (dc != 0);
            default:  take = (dc == 0) && (dr != 0);
          endcase
          rr = pr + dr;
          cc = pc + dc;
          if (take && rr >= 0 && rr < h && cc >= 0 && cc < w &&
              wr + dr >= 0 && wr + dr <= 2 && wc + dc >= 0 && wc + dc <= 2) begin
            sum += win[(wr + dr) * 3 + wc + dc];
            n++;
          end
        end
      end
      return (n == 0) ? '0 : PIX_W'(sum / n);
    endfunction

    function void push_pixel(int pr, int pc, int wr, int wc, int w, int h);
      pixel_t           px;
      logic [PIX_W-1:0] own;
      own = win[wr * 3 + wc];
      case ({pr[0], pc[0]})
        2'b00: begin
          px.color.red   = own;
          px.color.green = neighbor_mean(NB_CROSS, pr, pc, wr, wc, w, h);
          px.color.blue  = neighbor_mean(NB_DIAG, pr, pc, wr, wc, w, h);
        end
        2'b01: begin
          px.color.red   = neighbor_mean(NB_HORIZ, pr, pc, wr, wc, w, h);
          px.color.green = own;
          px.color.blue  = neighbor_mean(NB_VERT, pr, pc, wr, wc, w, h);
        end
        2'b10: begin
          px.color.red   = neighbor_mean(NB_VERT, pr, pc, wr, wc, w, h);
          px.color.green = own;
          px.color.blue  = neighbor_mean(NB_HORIZ, pr, pc, wr, wc, w, h);
        end
        default: begin
          px.color.red   = neighbor_mean(NB_DIAG, pr, pc, wr, wc, w, h);
          px.color.green = neighbor_mean(NB_CROSS, pr, pc, wr, wc, w, h);
          px.color.blue  = own;
        end
      endcase
      px.last_of_run = 1'b0;
      px.frame_end   = (pr == h - 1) && (pc == w - 1);
      expected_pixels.push_back(px);
    endfunction

    function void take_sample(logic [SAMPLE_W-1:0] raw);
      int               w;
      int               h;
      int               r;
      int               c;
      int               queued;
      pixel_t           tail;
      logic [PIX_W-1:0] s;
      w = eff_width();
      h = eff_height();
      if (col_count >= w) col_count = 0;
      if (row_count >= h) row_count = 0;
      r = row_count;
      c = col_count;
      s = raw[PIX_LSB +: PIX_W];
      win[0] = win[1];
      win[1] = win[2];
      win[3] = win[4];
      win[4] = win[5];
      win[6] = win[7];
      win[7] = win[8];
      win[2] = older_line[c];
      win[5] = newer_line[c];
      win[8] = s;
      older_line[c] = newer_line[c];
      newer_line[c] = s;
      queued = expected_pixels.size();
      if (r >= 1) begin
        if (c >= 1) push_pixel(r - 1, c - 1, 1, 1, w, h);
        if (c == w - 1) push_pixel(r - 1, c, 1, 2, w, h);
      end
      if (r == h - 1) begin
        if (c >= 1) push_pixel(r, c - 1, 2, 1, w, h);
        if (c == w - 1) push_pixel(r, c, 2, 2, w, h);
      end
      if (expected_pixels.size() > queued) begin
        tail = expected_pixels.pop_back();
        tail.last_of_run = 1'b1;
        expected_pixels.push_back(tail);
      end
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      col_count = c;
      row_count = r;
    endfunction

    function void check_pixel(rgb_t got, logic last_of_run, logic frame_end);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel: red %0d green %0d blue %0d", got.red, got.green, got.blue);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      if (got.red !== want.color.red) begin
        $error("red: expected %0d, got %0d", want.color.red, got.red);
        errors++;
      end
      if (got.green !== want.color.green) begin
        $error("green: expected %0d, got %0d", want.color.green, got.green);
        errors++;
      end
      if (got.blue !== want.color.blue) begin
        $error("blue: expected %0d, got %0d", want.color.blue, got.blue);
        errors++;
      end
      if (last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %0d, got %0d", want.last_of_run, last_of_run);
        errors++;
      end
      if (frame_end !== want.frame_end) begin
        $error("frame_end: expected %0d, got %0d", want.frame_end, frame_end);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_stall_o;
  logic [SAMPLE_W-1:0]   raw_sample_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i  = 1'b0;
  logic [PIX_W-1:0]      red_o;
  logic [PIX_W-1:0]      green_o;
  logic [PIX_W-1:0]      blue_o;
  logic                  last_of_run_o;
  logic                  frame_end_o;
  logic                  cfg_valid_i  = 1'b0;
  logic                  cfg_ready_o;
  reg_idx_e              cfg_index_i  = REG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;

  int                    send_idle_pct = 0;
  int                    stall_pct     = 0;
  logic [SAMPLE_W-1:0]   directed_raw [19];
  demosaic_scoreboard    sb;

  bayer_rg_bilinear_demosaic dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .raw_sample_i  (raw_sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .last_of_run_o (last_of_run_o),
    .frame_end_o   (frame_end_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_pixel('{red: red_o, green: green_o, blue: blue_o}, last_of_run_o, frame_end_o);
    end
    out_stall_i <= rst_ni && ($urandom_range(99) < stall_pct);
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] raw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    raw_sample_i <= raw;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.take_sample(raw);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_pixels.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_frame_size(input logic [CFG_DATA_W-1:0] width_data,
                                input logic [CFG_DATA_W-1:0] height_data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_FRAME_WIDTH;
    cfg_data_i  <= width_data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_register(REG_FRAME_WIDTH, width_data);
    cfg_index_i <= REG_FRAME_HEIGHT;
    cfg_data_i  <= height_data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_register(REG_FRAME_HEIGHT, height_data);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic feed(input int count, input int pause_at);
    int i;
    for (i = 0; i < count; i++) begin
      if (i == pause_at) drain();
      send_sample(SAMPLE_W'($urandom));
    end
  endtask

  task automatic run_random(input int quota);
    int fed;
    int w;
    int h;
    int k;
    int len;
    fed = 0;
    while (fed < quota) begin
      if (!sb.at_frame_start() && sb.samples_left() <= 64 && $urandom_range(2) != 0) begin
        len = sb.samples_left();
      end else begin
        k = $urandom_range(9);
        if (k <= 5) begin
          w = 2 * $urandom_range(4, 1);
          h = 2 * $urandom_range(3, 1);
        end else if (k <= 7) begin
          w = $urandom_range(9);
          h = $urandom_range(5);
        end else if (k == 8) begin
          w = 2 * $urandom_range(3, 1);
          h = 65534 + $urandom_range(1);
        end else begin
          w = 2 * $urandom_range(16, 1);
          h = 2 * $urandom_range(2, 1);
        end
        // Growing the row mid-frame would read line memory never written.
        if (!sb.at_frame_start() && w > sb.eff_width()) w = $urandom_range(sb.eff_width(), 1);
        set_frame_size({3'($urandom), WIDTH_REG_W'(w)}, HEIGHT_REG_W'(h));
        len = sb.samples_left();
        if (len > 128 || $urandom_range(4) == 0) len = $urandom_range((len < 48) ? len : 48, 1);
      end
      feed(len, ($urandom_range(9) == 0) ? $urandom_range(len - 1) : -1);
      fed += len;
    end
  endtask

  initial begin
    int i;
    sb = new();
    directed_raw = '{16'h0000, 16'hFFFF, 16'h0FF0, 16'h0010, 16'hF00F, 16'h0FE0, 16'h5A5A,
                     16'hA5A5, 16'h0FF0, 16'h8008, 16'hFFF0, 16'h000F, 16'h0800, 16'h07F0,
                     16'h1230, 16'hFED0, 16'h0FF0, 16'h0000, 16'h0AB0};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_frame_size(16'd4, 16'd2);
    for (i = 0; i < 19; i++) begin
      if (i == 8) set_frame_size(16'd0, 16'd0);
      if (i == 10) set_frame_size(16'd3, 16'd3);
      if (i == 14) drain();
      send_sample(directed_raw[i]);
    end
    set_frame_size(16'h1FFF, 16'd1);
    feed(16, -1);
    run_random(40);
    send_idle_pct = 87;
    run_random(40);
    send_idle_pct = 0;
    stall_pct     = 87;
    run_random(40);
    send_idle_pct = 8;
    stall_pct     = 8;
    run_random(40);
    drain();
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire
